// File: hdl/two_level_page_walk_demand_alloc_defines.svh
// Assertion macros shared by the page walk design.
`ifndef TWO_LEVEL_PAGE_WALK_DEMAND_ALLOC_DEFINES_SVH
`define TWO_LEVEL_PAGE_WALK_DEMAND_ALLOC_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define PGW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page walk check failed");

// Check that a condition implies another in the next cycle.
`define PGW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page walk sequence check failed");

`endif

// File: hdl/pgw_pkg.sv
// Shared types and constants of the page walk block.
package pgw_pkg;

  localparam int VA_WIDTH = 32;
  localparam int PA_WIDTH = 17;

  // Control from the walk sequencer to both stores.
  typedef struct packed {
    logic rd;      // read directory and frame entries of the page
    logic chk;     // read the owner entry of the stored frame
    logic commit;  // mark the directory slot present
    logic alloc;   // map the page to the next free frame
  } walk_ctl_t;

  // Status from the frame store.
  typedef struct packed {
    logic hit;     // page already mapped
    logic avail;   // a free frame remains
  } frm_sts_t;

endpackage

// File: hdl/two_level_page_walk_demand_alloc.sv
// Top level of the two-level page walk with demand frame allocation.
//
// Each item passes through ST_IDLE, ST_CHK and ST_WR: the accept cycle issues
// the directory and page memory reads, the next cycle reads the owner memory
// at the stored frame, and ST_WR decides, writes back and registers the
// result. The result is shown with out_strobe for one cycle, in which the next
// item may be accepted; a new item is taken only once the last one is through,
// since the read of the owner memory depends on the page memory read. After
// reset busy stays high while the directory memory is cleared. The receiver
// cannot stall: results must be captured in their strobe cycle.
`include "two_level_page_walk_demand_alloc_defines.svh"

module two_level_page_walk_demand_alloc #(
  parameter int DIR_INDEX_BITS   = 10,
  parameter int TABLE_INDEX_BITS = 10,
  parameter int OFFSET_BITS      = 12,
  parameter int FRAME_COUNT      = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [pgw_pkg::VA_WIDTH-1:0]     in_virtual_address,
  output logic                             busy,
  output logic                             out_strobe,
  output logic                             out_status,
  output logic [pgw_pkg::PA_WIDTH-1:0]     out_physical_address,
  output logic                             out_newly_mapped,
  output logic                             out_table_created
);
  import pgw_pkg::*;

  localparam int PAGE_BITS  = DIR_INDEX_BITS + TABLE_INDEX_BITS;
  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int PAW        = FRAME_BITS + OFFSET_BITS + PA_WIDTH;
  localparam int VA_EXT     = PAGE_BITS + OFFSET_BITS + VA_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHK  = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic                   accept;
  logic                   dir_ready;
  logic                   present;
  logic [VA_EXT-1:0]      va_ext;
  logic [PAGE_BITS-1:0]   in_page;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [PAGE_BITS-1:0]   page_idx;
  walk_ctl_t              ctl;
  frm_sts_t               sts;
  logic [FRAME_BITS-1:0]  frame;
  logic [PAW-1:0]         pa_wide;

  logic                   out_strobe_r;
  logic                   out_status_r;
  logic [PA_WIDTH-1:0]    out_physical_address_r;
  logic                   out_newly_mapped_r;
  logic                   out_table_created_r;

  // Split the address; bits above the directory index drop out
  assign va_ext  = VA_EXT'(in_virtual_address);
  assign in_page = va_ext[OFFSET_BITS +: PAGE_BITS];

  assign busy     = (state_r != ST_IDLE) || !dir_ready;
  assign accept   = start && !busy;
  assign page_idx = accept ? in_page : page_r;

  // Drive the store controls from the sequencer
  assign ctl.rd     = accept;
  assign ctl.chk    = state_r == ST_CHK;
  assign ctl.commit = state_r == ST_WR;
  assign ctl.alloc  = (state_r == ST_WR) && !sts.hit && sts.avail;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= state_r == ST_WR;
    end
  end

  // Hold the page and offset of the item under way
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r   <= in_page;
      offset_r <= in_virtual_address[OFFSET_BITS-1:0];
    end
  end

  pgw_dir_store #(
    .DIR_INDEX_BITS (DIR_INDEX_BITS)
  ) u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .dir_idx (page_idx[PAGE_BITS-1 -: DIR_INDEX_BITS]),
    .present (present),
    .ready   (dir_ready)
  );

  pgw_frame_store #(
    .PAGE_BITS   (PAGE_BITS),
    .FRAME_COUNT (FRAME_COUNT),
    .FRAME_BITS  (FRAME_BITS)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .page_idx (page_idx),
    .sts      (sts),
    .frame    (frame)
  );

  // Form the physical address and register the result
  assign pa_wide = (PAW'(frame) << OFFSET_BITS) | PAW'(offset_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_WR) begin
      out_status_r        <= !sts.hit && !sts.avail;
      out_newly_mapped_r  <= !sts.hit && sts.avail;
      out_table_created_r <= !present;
      if (sts.hit || sts.avail) begin
        out_physical_address_r <= pa_wide[PA_WIDTH-1:0];
      end else begin
        out_physical_address_r <= '0;
      end
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_status           = out_status_r;
  assign out_physical_address = out_physical_address_r;
  assign out_newly_mapped     = out_newly_mapped_r;
  assign out_table_created    = out_table_created_r;

  `PGW_ASSERT_IMP(a_alloc_has_frame, clk, rst_n, ctl.alloc, sts.avail)
  `PGW_ASSERT_NXT(a_wr_strobes, clk, rst_n, state_r == ST_WR, out_strobe_r)
  `PGW_ASSERT_NXT(a_strobe_single, clk, rst_n, out_strobe_r, !out_strobe_r)
  `PGW_ASSERT_IMP(a_fault_clean, clk, rst_n, out_strobe_r && out_status_r, out_physical_address_r == '0 && !out_newly_mapped_r)
  `PGW_ASSERT_IMP(a_accept_after_clear, clk, rst_n, ctl.rd, dir_ready && state_r == ST_IDLE)

endmodule

// File: hdl/pgw_dir_store.sv
// Directory present-bit memory with its clearing sweep after reset.
module pgw_dir_store #(
  parameter int DIR_INDEX_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pgw_pkg::walk_ctl_t        ctl,
  input  logic [DIR_INDEX_BITS-1:0] dir_idx,
  output logic                      present,
  output logic                      ready
);
  import pgw_pkg::*;

  localparam int DIR_DEPTH = 2 ** DIR_INDEX_BITS;

  logic                      present_mem [DIR_DEPTH];
  logic                      present_q;
  logic                      clearing_r;
  logic                      clearing_nxt;
  logic [DIR_INDEX_BITS-1:0] clr_idx_r;
  logic [DIR_INDEX_BITS-1:0] clr_idx_nxt;

  // Advance the clearing sweep one entry per cycle
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == {DIR_INDEX_BITS{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // Write port: clear during the sweep, set on commit afterwards
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      present_mem[clr_idx_r] <= 1'b0;
    end else if (ctl.commit) begin
      present_mem[dir_idx] <= 1'b1;
    end
  end

  // Read port with registered data
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      present_q <= present_mem[dir_idx];
    end
  end

  assign present = present_q;
  assign ready   = !clearing_r;

endmodule

// File: hdl/pgw_frame_store.sv
// Page-to-frame memory, frame owner memory and free-frame counter.
module pgw_frame_store #(
  parameter int PAGE_BITS   = 20,
  parameter int FRAME_COUNT = 32,
  parameter int FRAME_BITS  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgw_pkg::walk_ctl_t    ctl,
  input  logic [PAGE_BITS-1:0]  page_idx,
  output pgw_pkg::frm_sts_t     sts,
  output logic [FRAME_BITS-1:0] frame
);
  import pgw_pkg::*;

  localparam int PAGE_DEPTH = 2 ** PAGE_BITS;
  localparam int FL_W       = $clog2(FRAME_COUNT + 1);

  logic [FRAME_BITS-1:0] frame_mem [PAGE_DEPTH];
  logic [PAGE_BITS-1:0]  owner_mem [FRAME_COUNT];
  logic [FRAME_BITS-1:0] frame_q;
  logic [PAGE_BITS-1:0]  owner_q;
  logic [FL_W-1:0]       frames_left_r;
  logic [FL_W-1:0]       frames_left_nxt;
  logic [FRAME_BITS-1:0] next_frame;
  logic                  in_range;
  logic                  allocated;

  // Next free frame counts down from the top
  assign frames_left_nxt = frames_left_r - 1'b1;
  assign next_frame      = frames_left_nxt[FRAME_BITS-1:0];

  // A stored frame counts only if handed out and owned by this page
  assign in_range  = FL_W'(frame_q) < FL_W'(FRAME_COUNT);
  assign allocated = FL_W'(frame_q) >= frames_left_r;
  assign sts.hit   = in_range && allocated && (owner_q == page_idx);
  assign sts.avail = frames_left_r != '0;
  assign frame     = sts.hit ? frame_q : next_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_left_r <= FL_W'(FRAME_COUNT);
    end else if (ctl.alloc) begin
      frames_left_r <= frames_left_nxt;
    end
  end

  // Page memory: read on lookup, write on allocation
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      frame_q <= frame_mem[page_idx];
    end
    if (ctl.alloc) begin
      frame_mem[page_idx] <= next_frame;
    end
  end

  // Owner memory: read at the stored frame, write on allocation
  always_ff @(posedge clk) begin
    if (ctl.chk && in_range) begin
      owner_q <= owner_mem[frame_q];
    end
    if (ctl.alloc) begin
      owner_mem[next_frame] <= page_idx;
    end
  end

endmodule
